// ===== rtl/line_follow_pid_step_unit_macros.svh =====
// ----------------------------------------------------------------------------
// Line follower PID step unit: assertion macros
// Short forms for the concurrent checks of the block. Each expects signals
// named clock and reset in the module that uses it.
// ----------------------------------------------------------------------------
`ifndef LINE_FOLLOW_PID_STEP_UNIT_MACROS_SVH
`define LINE_FOLLOW_PID_STEP_UNIT_MACROS_SVH

// Same-cycle implication.
`define LFSU_ASSERT_IMPLY(lbl, ant, con, msg) \
   lbl: assert property (@(posedge clock) disable iff (reset) (ant) |-> (con)) \
      else $error(msg);

// Next-cycle implication.
`define LFSU_ASSERT_NEXT(lbl, ant, con, msg) \
   lbl: assert property (@(posedge clock) disable iff (reset) (ant) |=> (con)) \
      else $error(msg);

`endif

// ===== rtl/lfp_pkg.sv =====
// ----------------------------------------------------------------------------
// Line follower PID step package
// Widths, codes, register layout and the sensor pattern table.
// ----------------------------------------------------------------------------
package lfp_pkg;

   localparam int SENSOR_COUNT = 8;
   localparam int HEAD_W       = 16;
   localparam int TIME_W       = 32;
   localparam int PWM_W        = 10;
   localparam int STATUS_W     = 2;
   localparam int GAIN_W       = 16;
   localparam int CSR_IDX_W    = 3;
   localparam int CSR_DATA_W   = 16;
   localparam int SUM_W        = 32;
   localparam int ERR_W        = 16;
   localparam int PROD_W       = GAIN_W + 1 + SUM_W;
   localparam int ACC_W        = PROD_W + 1;
   localparam int DIV_W        = 14;
   localparam int DIVISOR_W    = 4;

   // Commands
   localparam logic CMD_START = 1'b0;
   localparam logic CMD_STEP  = 1'b1;

   // Run phases, also the run_status codes
   localparam logic [STATUS_W-1:0] PH_RUN     = 2'd0;
   localparam logic [STATUS_W-1:0] PH_TURN    = 2'd1;
   localparam logic [STATUS_W-1:0] PH_TIMEOUT = 2'd2;
   localparam logic [STATUS_W-1:0] PH_IDLE    = 2'd3;

   // Register indexes
   localparam logic [CSR_IDX_W-1:0] CSR_KP_GAIN         = 3'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_KI_GAIN         = 3'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_KD_GAIN         = 3'd2;
   localparam logic [CSR_IDX_W-1:0] CSR_DIFF_LIMIT      = 3'd3;
   localparam logic [CSR_IDX_W-1:0] CSR_BASE_SPEED      = 3'd4;
   localparam logic [CSR_IDX_W-1:0] CSR_YAW_THRESHOLD   = 3'd5;
   localparam logic [CSR_IDX_W-1:0] CSR_WHITE_DEBOUNCE  = 3'd6;
   localparam logic [CSR_IDX_W-1:0] CSR_TIMEOUT_SECONDS = 3'd7;

   localparam logic [PWM_W-1:0] PWM_MAX = 10'd999;

   localparam logic signed [17:0] HEAD_HALF = 18'sd18000;
   localparam logic signed [17:0] HEAD_FULL = 18'sd36000;

   typedef struct packed {
      logic [GAIN_W-1:0] kp_gain;
      logic [GAIN_W-1:0] ki_gain;
      logic [GAIN_W-1:0] kd_gain;
      logic [9:0]        diff_limit;
      logic [9:0]        base_speed;
      logic [14:0]       yaw_threshold;
      logic [7:0]        white_debounce;
      logic [15:0]       timeout_seconds;
   } cfg_type;

   localparam cfg_type CFG_RESET = '{
      kp_gain:         16'd2560,
      ki_gain:         16'd0,
      kd_gain:         16'd1280,
      diff_limit:      10'd500,
      base_speed:      10'd400,
      yaw_threshold:   15'd9000,
      white_debounce:  8'd3,
      timeout_seconds: 16'd30
   };

   typedef struct packed {
      logic clear;
      logic mul_en;
      logic acc_en;
   } mac_ctl_type;

   typedef struct packed {
      logic                    hit;
      logic signed [ERR_W-1:0] err;
   } pattern_type;

   // Known sensor patterns and their line error in Q.8.
   function automatic pattern_type pattern_lookup(input logic [SENSOR_COUNT-1:0] bits);
      pattern_type res;
      res.hit = 1'b1;
      res.err = '0;
      case (bits) inside
         8'h01, 8'h03, 8'h07: res.err = -16'sd1792;
         8'h02, 8'h06:        res.err = -16'sd1280;
         8'h0E:               res.err = -16'sd1024;
         8'h04, 8'h0C:        res.err = -16'sd768;
         8'h08, 8'h1C:        res.err = -16'sd256;
         8'h18:               res.err = 16'sd0;
         8'h10, 8'h38:        res.err = 16'sd256;
         8'h20, 8'h30:        res.err = 16'sd768;
         8'h70:               res.err = 16'sd1024;
         8'h40, 8'h60:        res.err = 16'sd1280;
         8'h80, 8'hC0, 8'hE0: res.err = 16'sd1792;
         default:             res.hit = 1'b0;
      endcase
      return res;
   endfunction

endpackage

// ===== rtl/lfp_channels.sv =====
// ----------------------------------------------------------------------------
// Line follower PID step channels
// Valid/ready channels for request words, response words and register writes.
// ----------------------------------------------------------------------------
interface lfp_req_if;
   logic                               valid;
   logic                               ready;
   logic                               cmd;
   logic [lfp_pkg::SENSOR_COUNT-1:0]   sensor_bits;
   logic signed [lfp_pkg::HEAD_W-1:0]  heading;
   logic [lfp_pkg::TIME_W-1:0]         now_ms;

   modport source (output valid, cmd, sensor_bits, heading, now_ms, input ready);
   modport sink   (input valid, cmd, sensor_bits, heading, now_ms, output ready);
endinterface

interface lfp_rsp_if;
   logic                               valid;
   logic                               ready;
   logic [lfp_pkg::PWM_W-1:0]          left_pwm;
   logic [lfp_pkg::PWM_W-1:0]          right_pwm;
   logic [lfp_pkg::STATUS_W-1:0]       run_status;
   logic signed [lfp_pkg::HEAD_W-1:0]  heading_change;

   modport source (output valid, left_pwm, right_pwm, run_status, heading_change,
                   input ready);
   modport sink   (input valid, left_pwm, right_pwm, run_status, heading_change,
                   output ready);
endinterface

interface lfp_csr_if;
   logic                               valid;
   logic                               ready;
   logic [lfp_pkg::CSR_IDX_W-1:0]      index;
   logic [lfp_pkg::CSR_DATA_W-1:0]     data;

   modport source (output valid, index, data, input ready);
   modport sink   (input valid, index, data, output ready);
endinterface

// ===== rtl/lfp_csr_regs.sv =====
// ----------------------------------------------------------------------------
// Line follower PID step register file
// Holds the eight configuration registers; writes are always taken.
// ----------------------------------------------------------------------------
module lfp_csr_regs (
   input  logic             clock,
   input  logic             reset,
   lfp_csr_if.sink          csr_chan,
   output lfp_pkg::cfg_type cfg
);
   import lfp_pkg::*;

   cfg_type cfg_ff;
   cfg_type cfg_in;

   assign csr_chan.ready = 1'b1;
   assign cfg            = cfg_ff;

   always_comb begin
      cfg_in = cfg_ff;
      if (csr_chan.valid) begin
         unique case (csr_chan.index)
            CSR_KP_GAIN:         cfg_in.kp_gain         = csr_chan.data;
            CSR_KI_GAIN:         cfg_in.ki_gain         = csr_chan.data;
            CSR_KD_GAIN:         cfg_in.kd_gain         = csr_chan.data;
            CSR_DIFF_LIMIT:      cfg_in.diff_limit      = csr_chan.data[9:0];
            CSR_BASE_SPEED:      cfg_in.base_speed      = csr_chan.data[9:0];
            CSR_YAW_THRESHOLD:   cfg_in.yaw_threshold   = csr_chan.data[14:0];
            CSR_WHITE_DEBOUNCE:  cfg_in.white_debounce  = csr_chan.data[7:0];
            CSR_TIMEOUT_SECONDS: cfg_in.timeout_seconds = csr_chan.data;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff <= CFG_RESET;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

endmodule

// ===== rtl/lfp_div.sv =====
// ----------------------------------------------------------------------------
// Line follower PID step divider
// Restoring unsigned divider, one quotient bit per cycle, for the centroid.
// ----------------------------------------------------------------------------
module lfp_div (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              start,
   input  logic [lfp_pkg::DIV_W-1:0]         dividend,
   input  logic [lfp_pkg::DIVISOR_W-1:0]     divisor,
   output logic                              done,
   output logic [lfp_pkg::DIV_W-1:0]         quotient
);
   import lfp_pkg::*;

   localparam int CNT_W = $clog2(DIV_W + 1);

   logic [DIV_W-1:0]     quo_ff, quo_in;
   logic [DIVISOR_W-1:0] rem_ff, rem_in;
   logic [DIVISOR_W-1:0] dvs_ff, dvs_in;
   logic [CNT_W-1:0]     cnt_ff, cnt_in;
   logic [DIVISOR_W:0]   trial;
   logic                 fits;

   // Shift the next dividend bit into the partial remainder and try it.
   assign trial    = {rem_ff, quo_ff[DIV_W-1]};
   assign fits     = trial >= {1'b0, dvs_ff};
   assign done     = cnt_ff == '0;
   assign quotient = quo_ff;

   always_comb begin
      quo_in = quo_ff;
      rem_in = rem_ff;
      dvs_in = dvs_ff;
      cnt_in = cnt_ff;
      if (start) begin
         quo_in = dividend;
         rem_in = '0;
         dvs_in = divisor;
         cnt_in = CNT_W'(DIV_W);
      end else if (!done) begin
         quo_in = {quo_ff[DIV_W-2:0], fits};
         rem_in = fits ? DIVISOR_W'(trial - {1'b0, dvs_ff}) : trial[DIVISOR_W-1:0];
         cnt_in = cnt_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cnt_ff <= '0;
      end else begin
         cnt_ff <= cnt_in;
      end
      quo_ff <= quo_in;
      rem_ff <= rem_in;
      dvs_ff <= dvs_in;
   end

endmodule

// ===== rtl/lfp_mac.sv =====
// ----------------------------------------------------------------------------
// Line follower PID step multiply-accumulate
// One registered gain-by-term multiplier feeding a wide accumulator.
// ----------------------------------------------------------------------------
module lfp_mac (
   input  logic                              clock,
   input  lfp_pkg::mac_ctl_type              ctl,
   input  logic [lfp_pkg::GAIN_W-1:0]        gain,
   input  logic signed [lfp_pkg::SUM_W-1:0]  operand,
   output logic signed [lfp_pkg::ACC_W-1:0]  acc
);
   import lfp_pkg::*;

   logic signed [GAIN_W:0]   gain_s;
   logic signed [PROD_W-1:0] prod_ff, prod_in;
   logic signed [ACC_W-1:0]  acc_ff, acc_in;

   assign gain_s  = {1'b0, gain};
   assign prod_in = gain_s * operand;
   assign acc     = acc_ff;

   always_comb begin
      acc_in = acc_ff;
      if (ctl.clear) begin
         acc_in = '0;
      end else if (ctl.acc_en) begin
         acc_in = acc_ff + {prod_ff[PROD_W-1], prod_ff};
      end
   end

   always_ff @(posedge clock) begin
      if (ctl.mul_en) begin
         prod_ff <= prod_in;
      end
      acc_ff <= acc_in;
   end

endmodule

// ===== rtl/line_follow_pid_step_unit.sv =====
// Flow: a start word, or a step that stops, times out or sees all white, goes
// from evaluation straight to the response; a pattern table step goes through
// sum, multiply, accumulate, scale and clamp; a centroid step divides first.
// One word is taken at a time; the gain terms share one multiplier.
// Reset: registers go to their defaults, state clears, phase becomes idle.
// ----------------------------------------------------------------------------
// Line follower PID step unit
// Sequenced controller: timeout, heading wrap, turn stop, line error, PID.
// ----------------------------------------------------------------------------
`include "line_follow_pid_step_unit_macros.svh"

module line_follow_pid_step_unit (
   input logic        clock,
   input logic        reset,
   lfp_req_if.sink    req_chan,
   lfp_rsp_if.source  rsp_chan,
   lfp_csr_if.sink    csr_chan
);
   import lfp_pkg::*;

   // Sequencer states
   localparam logic [3:0] S_IDLE  = 4'd0;
   localparam logic [3:0] S_EVAL  = 4'd1;
   localparam logic [3:0] S_DIV   = 4'd2;
   localparam logic [3:0] S_SUM   = 4'd3;
   localparam logic [3:0] S_MUL_P = 4'd4;
   localparam logic [3:0] S_MUL_I = 4'd5;
   localparam logic [3:0] S_MUL_D = 4'd6;
   localparam logic [3:0] S_ACC   = 4'd7;
   localparam logic [3:0] S_SCALE = 4'd8;
   localparam logic [3:0] S_CLAMP = 4'd9;
   localparam logic [3:0] S_DONE  = 4'd10;

   cfg_type cfg;

   logic [3:0]                      state_ff, state_in;

   // Captured request word
   logic                            cmd_ff, cmd_in;
   logic [SENSOR_COUNT-1:0]         bits_ff, bits_in;
   logic signed [HEAD_W-1:0]        heading_ff, heading_in;
   logic [TIME_W-1:0]               now_ff, now_in;

   // Controller state kept across words
   logic signed [HEAD_W-1:0]        start_heading_ff, start_heading_in;
   logic [TIME_W-1:0]               start_time_ff, start_time_in;
   logic signed [SUM_W-1:0]         error_sum_ff, error_sum_in;
   logic signed [ERR_W-1:0]         last_error_ff, last_error_in;
   logic [7:0]                      white_run_ff, white_run_in;
   logic [STATUS_W-1:0]             phase_ff, phase_in;

   // Working values of the current step
   logic signed [ERR_W-1:0]         err_ff, err_in;
   logic signed [ERR_W:0]           deriv_ff, deriv_in;
   logic                            neg_ff, neg_in;
   logic signed [HEAD_W-1:0]        delta_ff, delta_in;
   logic signed [ACC_W-17:0]        diff_ff, diff_in;
   logic [PWM_W-1:0]                res_left_ff, res_left_in;
   logic [PWM_W-1:0]                res_right_ff, res_right_in;
   logic [STATUS_W-1:0]             res_status_ff, res_status_in;

   // Output register
   logic                            rsp_valid_ff, rsp_valid_in;
   logic [PWM_W-1:0]                rsp_left_ff, rsp_left_in;
   logic [PWM_W-1:0]                rsp_right_ff, rsp_right_in;
   logic [STATUS_W-1:0]             rsp_status_ff, rsp_status_in;
   logic signed [HEAD_W-1:0]        rsp_hc_ff, rsp_hc_in;

   // Datapath nets
   logic signed [17:0]              hd_diff, hd_wrap;
   logic signed [HEAD_W-1:0]        delta_wrap;
   logic [TIME_W-1:0]               elapsed, limit_ms;
   logic                            timed_out;
   logic signed [HEAD_W:0]          delta17, thr_s;
   logic                            far_turn, all_white, turn_stop;
   logic [7:0]                      wr_inc;
   logic [PWM_W-1:0]                base_clamped;
   logic [4:0]                      pos_sum;
   logic [DIVISOR_W-1:0]            bit_cnt;
   logic [7:0]                      num_u;
   logic [7:0]                      num_mag;
   logic                            cent_neg;
   logic [DIV_W-1:0]                dividend;
   logic                            div_start, div_done;
   logic [DIV_W-1:0]                div_quo;
   logic signed [ERR_W-1:0]         quo_s;
   pattern_type                     pat;
   logic signed [SUM_W:0]           sum_wide;
   logic signed [SUM_W-1:0]         sum_sat;
   mac_ctl_type                     mac_ctl;
   logic [GAIN_W-1:0]               mac_gain;
   logic signed [SUM_W-1:0]         mac_operand;
   logic signed [ACC_W-1:0]         acc;
   logic signed [ACC_W-1:0]         acc_adj;
   logic signed [ACC_W-17:0]        lim_s, diff_cl;
   logic signed [10:0]              diff11;
   logic signed [11:0]              left_s, right_s;

   function automatic logic [PWM_W-1:0] clamp_pwm(input logic signed [11:0] v);
      logic [PWM_W-1:0] r;
      if (v > $signed({2'b00, PWM_MAX})) begin
         r = PWM_MAX;
      end else if (v < 12'sd0) begin
         r = '0;
      end else begin
         r = v[PWM_W-1:0];
      end
      return r;
   endfunction

   // ---------------------------------------------------------------------
   // Units
   // ---------------------------------------------------------------------
   lfp_csr_regs u_csr (
      .clock    (clock),
      .reset    (reset),
      .csr_chan (csr_chan),
      .cfg      (cfg)
   );

   lfp_div u_div (
      .clock    (clock),
      .reset    (reset),
      .start    (div_start),
      .dividend (dividend),
      .divisor  (bit_cnt),
      .done     (div_done),
      .quotient (div_quo)
   );

   lfp_mac u_mac (
      .clock   (clock),
      .ctl     (mac_ctl),
      .gain    (mac_gain),
      .operand (mac_operand),
      .acc     (acc)
   );

   // ---------------------------------------------------------------------
   // Heading change: wrap once by a full turn, then saturate to a half turn
   // ---------------------------------------------------------------------
   assign hd_diff = {{2{heading_ff[HEAD_W-1]}}, heading_ff}
                  - {{2{start_heading_ff[HEAD_W-1]}}, start_heading_ff};

   always_comb begin
      hd_wrap = hd_diff;
      if (hd_wrap > HEAD_HALF) begin
         hd_wrap = hd_wrap - HEAD_FULL;
      end
      if (hd_wrap < -HEAD_HALF) begin
         hd_wrap = hd_wrap + HEAD_FULL;
      end
      if (hd_wrap > HEAD_HALF) begin
         hd_wrap = HEAD_HALF;
      end
      if (hd_wrap < -HEAD_HALF) begin
         hd_wrap = -HEAD_HALF;
      end
   end

   assign delta_wrap = hd_wrap[HEAD_W-1:0];

   // ---------------------------------------------------------------------
   // Timeout: floor(elapsed / 1000) >= T exactly when elapsed >= 1000 * T
   // ---------------------------------------------------------------------
   assign elapsed   = now_ff - start_time_ff;
   assign limit_ms  = ({16'b0, cfg.timeout_seconds} << 10)
                    - ({16'b0, cfg.timeout_seconds} << 4)
                    - ({16'b0, cfg.timeout_seconds} << 3);
   assign timed_out = elapsed >= limit_ms;

   // ---------------------------------------------------------------------
   // All-white debounce while turned far enough
   // ---------------------------------------------------------------------
   assign delta17   = {delta_wrap[HEAD_W-1], delta_wrap};
   assign thr_s     = {2'b00, cfg.yaw_threshold};
   assign far_turn  = (delta17 > thr_s) || (delta17 < -thr_s);
   assign all_white = bits_ff == '0;
   assign wr_inc    = (white_run_ff == 8'hFF) ? 8'hFF : white_run_ff + 8'd1;
   assign turn_stop = wr_inc >= cfg.white_debounce;

   assign base_clamped = (cfg.base_speed > PWM_MAX) ? PWM_MAX : cfg.base_speed;

   // ---------------------------------------------------------------------
   // Line error: pattern table, else weighted centroid through the divider
   // ---------------------------------------------------------------------
   assign pat = pattern_lookup(bits_ff);

   always_comb begin
      pos_sum = '0;
      bit_cnt = '0;
      for (int i = 0; i < SENSOR_COUNT; i++) begin
         if (bits_ff[i]) begin
            pos_sum = pos_sum + 5'(i);
            bit_cnt = bit_cnt + 1'b1;
         end
      end
   end

   // 2*pos - 7*cnt, modulo 256; its sign picks the rounding direction
   assign num_u    = {2'b00, pos_sum, 1'b0} - ({4'b0, bit_cnt} << 3) + {4'b0, bit_cnt};
   assign cent_neg = num_u[7];
   assign num_mag  = cent_neg ? (8'd0 - num_u) : num_u;
   // |num| * 256 plus half the count rounds ties away from zero
   assign dividend = {num_mag[5:0], 8'b0} + DIV_W'(bit_cnt >> 1);
   assign quo_s    = {{(ERR_W-DIV_W){1'b0}}, div_quo};

   // ---------------------------------------------------------------------
   // Integral with saturation at the 32-bit limits
   // ---------------------------------------------------------------------
   assign sum_wide = {error_sum_ff[SUM_W-1], error_sum_ff}
                   + {{(SUM_W+1-ERR_W){err_ff[ERR_W-1]}}, err_ff};

   always_comb begin
      if (sum_wide[SUM_W] != sum_wide[SUM_W-1]) begin
         sum_sat = sum_wide[SUM_W] ? {1'b1, {(SUM_W-1){1'b0}}} : {1'b0, {(SUM_W-1){1'b1}}};
      end else begin
         sum_sat = sum_wide[SUM_W-1:0];
      end
   end

   // ---------------------------------------------------------------------
   // Shared multiplier operands: proportional, integral, derivative in turn
   // ---------------------------------------------------------------------
   always_comb begin
      case (state_ff)
         S_MUL_I: begin
            mac_gain    = cfg.ki_gain;
            mac_operand = error_sum_ff;
         end
         S_MUL_D: begin
            mac_gain    = cfg.kd_gain;
            mac_operand = {{(SUM_W-ERR_W-1){deriv_ff[ERR_W]}}, deriv_ff};
         end
         default: begin
            mac_gain    = cfg.kp_gain;
            mac_operand = {{(SUM_W-ERR_W){err_ff[ERR_W-1]}}, err_ff};
         end
      endcase
   end

   // ---------------------------------------------------------------------
   // Scale by 1/65536 toward zero, clamp the differential, form the duties
   // ---------------------------------------------------------------------
   assign acc_adj = acc + (acc[ACC_W-1] ? ACC_W'(65535) : '0);

   assign lim_s = {{(ACC_W-16-10){1'b0}}, cfg.diff_limit};

   always_comb begin
      if (diff_ff > lim_s) begin
         diff_cl = lim_s;
      end else if (diff_ff < -lim_s) begin
         diff_cl = -lim_s;
      end else begin
         diff_cl = diff_ff;
      end
   end

   assign diff11  = diff_cl[10:0];
   assign left_s  = $signed({2'b00, cfg.base_speed}) + {diff11[10], diff11};
   assign right_s = $signed({2'b00, cfg.base_speed}) - {diff11[10], diff11};

   // ---------------------------------------------------------------------
   // Sequencer
   // ---------------------------------------------------------------------
   always_comb begin
      state_in         = state_ff;
      cmd_in           = cmd_ff;
      bits_in          = bits_ff;
      heading_in       = heading_ff;
      now_in           = now_ff;
      start_heading_in = start_heading_ff;
      start_time_in    = start_time_ff;
      error_sum_in     = error_sum_ff;
      last_error_in    = last_error_ff;
      white_run_in     = white_run_ff;
      phase_in         = phase_ff;
      err_in           = err_ff;
      deriv_in         = deriv_ff;
      neg_in           = neg_ff;
      delta_in         = delta_ff;
      diff_in          = diff_ff;
      res_left_in      = res_left_ff;
      res_right_in     = res_right_ff;
      res_status_in    = res_status_ff;
      rsp_valid_in     = rsp_valid_ff;
      rsp_left_in      = rsp_left_ff;
      rsp_right_in     = rsp_right_ff;
      rsp_status_in    = rsp_status_ff;
      rsp_hc_in        = rsp_hc_ff;
      div_start        = 1'b0;
      mac_ctl          = '0;

      // Drop the response word once the sink takes it
      if (rsp_chan.ready) begin
         rsp_valid_in = 1'b0;
      end

      unique case (state_ff)
         S_IDLE: begin
            if (req_chan.valid) begin
               cmd_in     = req_chan.cmd;
               bits_in    = req_chan.sensor_bits;
               heading_in = req_chan.heading;
               now_in     = req_chan.now_ms;
               state_in   = S_EVAL;
            end
         end

         S_EVAL: begin
            // Early exits give zero duties, except a lost line, which runs straight
            delta_in      = delta_wrap;
            res_left_in   = '0;
            res_right_in  = '0;
            res_status_in = PH_RUN;
            state_in      = S_DONE;
            if (cmd_ff == CMD_START) begin
               start_heading_in = heading_ff;
               start_time_in    = now_ff;
               error_sum_in     = '0;
               last_error_in    = '0;
               white_run_in     = '0;
               phase_in         = PH_RUN;
               delta_in         = '0;
            end else if (phase_ff != PH_RUN) begin
               res_status_in = phase_ff;
            end else if (timed_out) begin
               phase_in      = PH_TIMEOUT;
               res_status_in = PH_TIMEOUT;
            end else begin
               if (all_white && far_turn) begin
                  white_run_in = wr_inc;
               end else begin
                  white_run_in = '0;
               end
               if (all_white && far_turn && turn_stop) begin
                  phase_in      = PH_TURN;
                  res_status_in = PH_TURN;
               end else if (all_white) begin
                  // Lost the line: clear I and D, run straight
                  error_sum_in = '0;
                  last_error_in = '0;
                  res_left_in  = base_clamped;
                  res_right_in = base_clamped;
               end else if (pat.hit) begin
                  err_in   = pat.err;
                  state_in = S_SUM;
               end else begin
                  div_start = 1'b1;
                  neg_in    = cent_neg;
                  state_in  = S_DIV;
               end
            end
         end

         S_DIV: begin
            if (div_done) begin
               err_in   = neg_ff ? -quo_s : quo_s;
               state_in = S_SUM;
            end
         end

         S_SUM: begin
            error_sum_in  = sum_sat;
            deriv_in      = {err_ff[ERR_W-1], err_ff} - {last_error_ff[ERR_W-1], last_error_ff};
            last_error_in = err_ff;
            mac_ctl.clear = 1'b1;
            state_in      = S_MUL_P;
         end

         S_MUL_P: begin
            mac_ctl.mul_en = 1'b1;
            state_in       = S_MUL_I;
         end

         S_MUL_I: begin
            mac_ctl.mul_en = 1'b1;
            mac_ctl.acc_en = 1'b1;
            state_in       = S_MUL_D;
         end

         S_MUL_D: begin
            mac_ctl.mul_en = 1'b1;
            mac_ctl.acc_en = 1'b1;
            state_in       = S_ACC;
         end

         S_ACC: begin
            mac_ctl.acc_en = 1'b1;
            state_in       = S_SCALE;
         end

         S_SCALE: begin
            diff_in  = acc_adj[ACC_W-1:16];
            state_in = S_CLAMP;
         end

         S_CLAMP: begin
            res_left_in  = clamp_pwm(left_s);
            res_right_in = clamp_pwm(right_s);
            state_in     = S_DONE;
         end

         S_DONE: begin
            // Hold until the output register is free
            if (!rsp_valid_ff || rsp_chan.ready) begin
               rsp_valid_in  = 1'b1;
               rsp_left_in   = res_left_ff;
               rsp_right_in  = res_right_ff;
               rsp_status_in = res_status_ff;
               rsp_hc_in     = delta_ff;
               state_in      = S_IDLE;
            end
         end

         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff         <= S_IDLE;
         start_heading_ff <= '0;
         start_time_ff    <= '0;
         error_sum_ff     <= '0;
         last_error_ff    <= '0;
         white_run_ff     <= '0;
         phase_ff         <= PH_IDLE;
         rsp_valid_ff     <= 1'b0;
      end else begin
         state_ff         <= state_in;
         start_heading_ff <= start_heading_in;
         start_time_ff    <= start_time_in;
         error_sum_ff     <= error_sum_in;
         last_error_ff    <= last_error_in;
         white_run_ff     <= white_run_in;
         phase_ff         <= phase_in;
         rsp_valid_ff     <= rsp_valid_in;
      end
      cmd_ff        <= cmd_in;
      bits_ff       <= bits_in;
      heading_ff    <= heading_in;
      now_ff        <= now_in;
      err_ff        <= err_in;
      deriv_ff      <= deriv_in;
      neg_ff        <= neg_in;
      delta_ff      <= delta_in;
      diff_ff       <= diff_in;
      res_left_ff   <= res_left_in;
      res_right_ff  <= res_right_in;
      res_status_ff <= res_status_in;
      rsp_left_ff   <= rsp_left_in;
      rsp_right_ff  <= rsp_right_in;
      rsp_status_ff <= rsp_status_in;
      rsp_hc_ff     <= rsp_hc_in;
   end

   // ---------------------------------------------------------------------
   // Ports
   // ---------------------------------------------------------------------
   assign req_chan.ready          = state_ff == S_IDLE;
   assign rsp_chan.valid          = rsp_valid_ff;
   assign rsp_chan.left_pwm       = rsp_left_ff;
   assign rsp_chan.right_pwm      = rsp_right_ff;
   assign rsp_chan.run_status     = rsp_status_ff;
   assign rsp_chan.heading_change = rsp_hc_ff;

   // ---------------------------------------------------------------------
   // Assertions
   // ---------------------------------------------------------------------
   `LFSU_ASSERT_NEXT(a_busy_after_accept, req_chan.valid && req_chan.ready, !req_chan.ready, "request taken while a word is in flight")
   `LFSU_ASSERT_NEXT(a_start_runs, (state_ff == S_EVAL) && (cmd_ff == CMD_START), phase_ff == PH_RUN, "start word did not enter the running phase")
   `LFSU_ASSERT_IMPLY(a_duty_range, rsp_valid_ff, (rsp_left_ff <= PWM_MAX) && (rsp_right_ff <= PWM_MAX), "duty beyond 999")
   `LFSU_ASSERT_IMPLY(a_stop_zero, rsp_valid_ff && (rsp_status_ff != PH_RUN), (rsp_left_ff == '0) && (rsp_right_ff == '0), "motors driven while not running")
   `LFSU_ASSERT_NEXT(a_div_leads_sum, (state_ff == S_DIV) && div_done, state_ff == S_SUM, "divider result not taken into the integral")

endmodule
